>>> src/bmpe_pkg.sv
`timescale 1ns / 1ps

package bmpe_pkg;

  // Field and counter widths
  localparam int LEVEL_W = 9;
  localparam int DIM_W   = 13;
  localparam int CNT_W   = 12;
  localparam int ROW_W   = 15;
  localparam int SIZE_W  = DIM_W + ROW_W;
  localparam int HCNT_W  = 6;

  // Largest image side in pixels
  localparam int MAX_DIM = 4096;

  // File layout constants
  localparam int FILE_HDR_BYTES = 14;
  localparam int INFO_HDR_BYTES = 40;
  localparam int HDR_BYTES      = FILE_HDR_BYTES + INFO_HDR_BYTES;
  localparam int BITS_PER_PIXEL = 24;

  localparam logic [7:0] CHAR_B = 8'h42;
  localparam logic [7:0] CHAR_M = 8'h4D;

  // Queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // Register map (word index on paddr[2])
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef logic [LEVEL_W-1:0] level_t;
  typedef logic [DIM_W-1:0]   dim_t;

  // One classified pixel, waiting for the byte sequencer
  typedef struct packed {
    logic       hdr;
    logic       img_end;
    logic [1:0] pad;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } bmpe_item_t;

  // Byte sequencer phases
  typedef enum logic [1:0] {
    PH_START,
    PH_HEADER,
    PH_PIXEL,
    PH_PAD
  } bmpe_phase_t;

endpackage

>>> src/bmpe_ifs.sv
`timescale 1ns / 1ps

// Pixel channel
interface bmpe_pixel_if import bmpe_pkg::*; ();
  logic   valid;
  logic   ready;
  level_t red_level;
  level_t green_level;
  level_t blue_level;

  modport source (output valid, red_level, green_level, blue_level, input ready);
  modport sink   (input valid, red_level, green_level, blue_level, output ready);
endinterface

// File byte channel
interface bmpe_byte_if import bmpe_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;
  logic       end_of_image;

  modport source (output valid, out_byte, last_of_run, end_of_image, input ready);
  modport sink   (input valid, out_byte, last_of_run, end_of_image, output ready);
endinterface

>>> src/bmp24_stream_encoder.sv
`timescale 1ns / 1ps

// Streams an uncompressed 24-bit BMP file from pixels given in raster order.
// pixel:  one beat per pixel with red, green and blue levels (9 bits, 256 = 1.0).
// stream: file bytes, one per beat. last_of_run marks the last byte a pixel
//         causes, end_of_image the last byte of the file.
// The first pixel of an image brings the 54 header bytes before its own three
// bytes (blue, green, red); the last pixel of a row adds (width mod 4) zero
// bytes. After the last row the next pixel opens a new file.
// Throughput: one output byte per cycle while the receiver is ready; a pixel
// gives 3 bytes, plus (width mod 4) at row end and 54 for the header; the byte
// sequencer sets this rate. A pixel's first byte passes a queue entry and then
// the output beat register. A two-entry queue lets new pixels in while bytes
// wait. When the receiver stalls, the output beat holds and the queue fills, then
// pixel.ready drops. Reset clears the raster position, the queue and the output,
// and sets width and height to 1. The user writes width and height (APB byte
// addresses 0 and 4) only while no pixel is in flight; the block doesn't enforce it.
module bmp24_stream_encoder import bmpe_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  bmpe_pixel_if.sink  pixel,
  bmpe_byte_if.source stream
);

  dim_t       image_width;
  dim_t       image_height;
  dim_t       wc;
  dim_t       hc;
  logic       push;
  logic       q_ready;
  logic       pop;
  logic       head_valid;
  bmpe_item_t front_item;
  bmpe_item_t head_item;

  // Configuration registers
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= dim_t'(1);
      image_height <= dim_t'(1);
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_WIDTH) begin
        image_width <= pwdata[DIM_W-1:0];
      end else begin
        image_height <= pwdata[DIM_W-1:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_HEIGHT) ? 32'(image_height) : 32'(image_width);

  // Clamp dimensions: zero reads as one, oversize as the maximum
  always_comb begin
    if (image_width == '0) begin
      wc = dim_t'(1);
    end else if (image_width > dim_t'(MAX_DIM)) begin
      wc = dim_t'(MAX_DIM);
    end else begin
      wc = image_width;
    end
    if (image_height == '0) begin
      hc = dim_t'(1);
    end else if (image_height > dim_t'(MAX_DIM)) begin
      hc = dim_t'(MAX_DIM);
    end else begin
      hc = image_height;
    end
  end

  bmpe_front u_front (
    .clk     (clk),
    .rst     (rst),
    .wc      (wc),
    .hc      (hc),
    .pixel   (pixel),
    .q_ready (q_ready),
    .push    (push),
    .item    (front_item)
  );

  bmpe_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (front_item),
    .in_ready   (q_ready),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  bmpe_back u_back (
    .clk        (clk),
    .rst        (rst),
    .wc         (wc),
    .hc         (hc),
    .head_valid (head_valid),
    .head_item  (head_item),
    .pop        (pop),
    .stream     (stream)
  );

endmodule

>>> src/bmpe_front.sv
`timescale 1ns / 1ps

module bmpe_front import bmpe_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  dim_t            wc,
  input  dim_t            hc,
  bmpe_pixel_if.sink      pixel,
  input  logic            q_ready,
  output logic            push,
  output bmpe_item_t      item
);

  logic [CNT_W-1:0] column_count;
  logic [CNT_W-1:0] row_count;
  logic             header_sent;
  logic             row_end;
  logic             img_end;

  // level * 255 / 256, truncated, saturating at 255
  function automatic logic [7:0] level_to_byte(input level_t lv);
    logic [LEVEL_W+7:0] prod;
    begin
      prod = {lv, 8'd0} - (LEVEL_W + 8)'(lv);
      level_to_byte = (prod[LEVEL_W+7:8] > (LEVEL_W)'(255)) ? 8'hFF : prod[15:8];
    end
  endfunction

  assign pixel.ready = q_ready;
  assign push        = pixel.valid && q_ready;

  // Row and image end; a count at or past the limit closes it
  always_comb begin
    row_end = (({1'b0, column_count} + dim_t'(1)) >= wc);
    img_end = row_end && (({1'b0, row_count} + dim_t'(1)) >= hc);
  end

  always_comb begin
    item.hdr     = !header_sent;
    item.img_end = img_end;
    item.pad     = row_end ? wc[1:0] : 2'd0;
    item.blue    = level_to_byte(pixel.blue_level);
    item.green   = level_to_byte(pixel.green_level);
    item.red     = level_to_byte(pixel.red_level);
  end

  // Raster position and header flag
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      header_sent  <= 1'b0;
    end else if (push) begin
      if (row_end) begin
        column_count <= '0;
        if (img_end) begin
          row_count   <= '0;
          header_sent <= 1'b0;
        end else begin
          row_count   <= row_count + CNT_W'(1);
          header_sent <= 1'b1;
        end
      end else begin
        column_count <= column_count + CNT_W'(1);
        header_sent  <= 1'b1;
      end
    end
  end

endmodule

>>> src/bmpe_queue.sv
`timescale 1ns / 1ps

module bmpe_queue import bmpe_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  bmpe_item_t push_item,
  output logic       in_ready,
  input  logic       pop,
  output logic       head_valid,
  output bmpe_item_t head_item
);

  bmpe_item_t         entries [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_CNT_W-1:0] fill;

  assign in_ready   = (fill != Q_CNT_W'(Q_DEPTH));
  assign head_valid = (fill != '0);
  assign head_item  = entries[rd_ptr];

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + Q_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + Q_PTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + Q_CNT_W'(1);
      end else if (pop && !push) begin
        fill <= fill - Q_CNT_W'(1);
      end
    end
  end

endmodule

>>> src/bmpe_back.sv
`timescale 1ns / 1ps

module bmpe_back import bmpe_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  dim_t        wc,
  input  dim_t        hc,
  input  logic        head_valid,
  input  bmpe_item_t  head_item,
  output logic        pop,
  bmpe_byte_if.source stream
);

  // Header byte offsets
  localparam logic [HCNT_W-1:0] OFS_SIZE   = HCNT_W'(2);
  localparam logic [HCNT_W-1:0] OFS_DATA   = HCNT_W'(10);
  localparam logic [HCNT_W-1:0] OFS_INFO   = HCNT_W'(FILE_HDR_BYTES);
  localparam logic [HCNT_W-1:0] OFS_WIDTH  = HCNT_W'(FILE_HDR_BYTES + 4);
  localparam logic [HCNT_W-1:0] OFS_HEIGHT = HCNT_W'(FILE_HDR_BYTES + 8);
  localparam logic [HCNT_W-1:0] OFS_PLANES = HCNT_W'(FILE_HDR_BYTES + 12);
  localparam logic [HCNT_W-1:0] OFS_BPP    = HCNT_W'(FILE_HDR_BYTES + 14);
  localparam logic [HCNT_W-1:0] HDR_LAST   = HCNT_W'(HDR_BYTES - 1);

  bmpe_phase_t              phase;
  bmpe_phase_t              phase_next;
  bmpe_phase_t              eff_phase;
  logic [HCNT_W-1:0]        cnt;
  logic [HCNT_W-1:0]        cnt_next;
  logic [ROW_W-1:0]         row_bytes;
  logic [DIM_W+ROW_W-1:0]   prod;
  logic [SIZE_W-1:0]        size_q;
  logic [31:0]              size32;
  logic [31:0]              w32;
  logic [31:0]              h32;
  logic [7:0]               hdr_byte;
  logic [7:0]               byte_sel;
  logic                     is_last;
  logic                     load;
  logic                     advance;
  logic                     out_valid;
  logic [7:0]               out_byte;
  logic                     out_last;
  logic                     out_eoi;

  // File size, two register stages from the dimension registers
  assign prod = hc * row_bytes;

  always_ff @(posedge clk) begin
    row_bytes <= ROW_W'(wc) + (ROW_W'(wc) << 1) + ROW_W'(wc[1:0]);
    size_q    <= SIZE_W'(prod) + SIZE_W'(HDR_BYTES);
  end

  assign size32 = 32'(size_q);
  assign w32    = 32'(wc);
  assign h32    = 32'(hc);

  // Header byte decoder
  always_comb begin
    unique case (cnt)
      HCNT_W'(0):     hdr_byte = CHAR_B;
      HCNT_W'(1):     hdr_byte = CHAR_M;
      OFS_SIZE:       hdr_byte = size32[7:0];
      OFS_SIZE + 1:   hdr_byte = size32[15:8];
      OFS_SIZE + 2:   hdr_byte = size32[23:16];
      OFS_SIZE + 3:   hdr_byte = size32[31:24];
      OFS_DATA:       hdr_byte = 8'(HDR_BYTES);
      OFS_INFO:       hdr_byte = 8'(INFO_HDR_BYTES);
      OFS_WIDTH:      hdr_byte = w32[7:0];
      OFS_WIDTH + 1:  hdr_byte = w32[15:8];
      OFS_WIDTH + 2:  hdr_byte = w32[23:16];
      OFS_WIDTH + 3:  hdr_byte = w32[31:24];
      OFS_HEIGHT:     hdr_byte = h32[7:0];
      OFS_HEIGHT + 1: hdr_byte = h32[15:8];
      OFS_HEIGHT + 2: hdr_byte = h32[23:16];
      OFS_HEIGHT + 3: hdr_byte = h32[31:24];
      OFS_PLANES:     hdr_byte = 8'd1;
      OFS_BPP:        hdr_byte = 8'(BITS_PER_PIXEL);
      default:        hdr_byte = 8'd0;
    endcase
  end

  // Output register is free when empty or being taken
  assign load    = !out_valid || stream.ready;
  assign advance = head_valid && load;
  assign pop     = advance && is_last;

  // Sequencer: next phase, byte select and end of run
  always_comb begin
    eff_phase = phase;
    if (phase == PH_START) begin
      eff_phase = head_item.hdr ? PH_HEADER : PH_PIXEL;
    end

    byte_sel = 8'd0;
    is_last  = 1'b0;
    unique case (eff_phase)
      PH_HEADER: byte_sel = hdr_byte;
      PH_PIXEL: begin
        case (cnt)
          HCNT_W'(0): byte_sel = head_item.blue;
          HCNT_W'(1): byte_sel = head_item.green;
          default:    byte_sel = head_item.red;
        endcase
        is_last = (cnt == HCNT_W'(2)) && (head_item.pad == 2'd0);
      end
      PH_PAD:   is_last = (cnt[1:0] == head_item.pad - 2'd1);
      default:  byte_sel = 8'd0;
    endcase

    phase_next = phase;
    cnt_next   = cnt;
    if (advance) begin
      if (is_last) begin
        phase_next = PH_START;
        cnt_next   = '0;
      end else begin
        unique case (eff_phase)
          PH_HEADER: begin
            if (cnt == HDR_LAST) begin
              phase_next = PH_PIXEL;
              cnt_next   = '0;
            end else begin
              phase_next = PH_HEADER;
              cnt_next   = cnt + HCNT_W'(1);
            end
          end
          PH_PIXEL: begin
            if (cnt == HCNT_W'(2)) begin
              phase_next = PH_PAD;
              cnt_next   = '0;
            end else begin
              phase_next = PH_PIXEL;
              cnt_next   = cnt + HCNT_W'(1);
            end
          end
          PH_PAD: begin
            phase_next = PH_PAD;
            cnt_next   = cnt + HCNT_W'(1);
          end
          default: begin
            phase_next = PH_START;
            cnt_next   = '0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_START;
      cnt   <= '0;
    end else begin
      phase <= phase_next;
      cnt   <= cnt_next;
    end
  end

  // Output beat register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= head_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_byte <= byte_sel;
      out_last <= is_last;
      out_eoi  <= is_last && head_item.img_end;
    end
  end

  assign stream.valid        = out_valid;
  assign stream.out_byte     = out_byte;
  assign stream.last_of_run  = out_last;
  assign stream.end_of_image = out_eoi;

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps

module tb;
  import bmpe_pkg::*;

  localparam int RANDOM_PIXELS  = 460;
  localparam int DRAIN_CYCLES   = 8;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int N_DIRECTED     = 28;

  // Kinds of rows in the directed table
  typedef enum logic [1:0] {
    DO_PIXEL,
    SET_WIDTH,
    SET_HEIGHT
  } step_kind_t;

  typedef struct {
    step_kind_t kind;
    dim_t       value;
    level_t     red;
    level_t     green;
    level_t     blue;
    logic       fixed;
    logic [7:0] exp_blue;
    logic [7:0] exp_green;
    logic [7:0] exp_red;
  } stim_row_t;

  // One byte of the file as it should come out
  typedef struct packed {
    logic [7:0] data;
    logic       run_end;
    logic       file_end;
  } file_byte_t;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  bmpe_pixel_if pixel();
  bmpe_byte_if  stream();

  bmp24_stream_encoder dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .pixel   (pixel),
    .stream  (stream)
  );

  // Typed-in pixel bytes, travel with the pixel beat
  logic       fixed_exp;
  logic [7:0] fixed_blue;
  logic [7:0] fixed_green;
  logic [7:0] fixed_red;

  // Encoder model state
  dim_t        enc_width  = 13'd1;
  dim_t        enc_height = 13'd1;
  int unsigned enc_col    = 0;
  int unsigned enc_row    = 0;
  bit          enc_hdr_sent = 1'b0;

  logic [7:0]  run_bytes[$];
  file_byte_t  file_bytes[$];
  int unsigned fail_count = 0;
  bit          quiet = 1'b0;
  int unsigned sink_hold = 0;
  int unsigned stall_cycles = 0;

  // Directed rows: extremes, saturation, clamped sizes, mid-image size changes
  stim_row_t directed_rows [N_DIRECTED] = '{
    '{DO_PIXEL,   13'd0,    9'd0,   9'd0,   9'd0,   1'b1, 8'd0,   8'd0,   8'd0},
    '{DO_PIXEL,   13'd0,    9'd256, 9'd256, 9'd256, 1'b1, 8'd255, 8'd255, 8'd255},
    '{DO_PIXEL,   13'd0,    9'd511, 9'd511, 9'd511, 1'b1, 8'd255, 8'd255, 8'd255},
    '{DO_PIXEL,   13'd0,    9'd255, 9'd1,   9'd128, 1'b1, 8'd127, 8'd0,   8'd254},
    '{DO_PIXEL,   13'd0,    9'd257, 9'd300, 9'd384, 1'b1, 8'd255, 8'd255, 8'd255},
    '{SET_WIDTH,  13'd0,    9'd0,   9'd0,   9'd0,   1'b0, 8'd0,   8'd0,   8'd0},
    '{SET_HEIGHT, 13'd0,    9'd0,   9'd0,   9'd0,   1'b0, 8'd0,   8'd0,   8'd0},
    '{DO_PIXEL,   13'd0,    9'd128, 9'd64,  9'd32,  1'b0, 8'd0,   8'd0,   8'd0},
    '{SET_WIDTH,  13'd8191, 9'd0,   9'd0,   9'd0,   1'b0, 8'd0,   8'd0,   8'd0},
    '{SET_HEIGHT, 13'd4097, 9'd0,   9'd0,   9'd0,   1'b0, 8'd0,   8'd0,   8'd0},
    '{DO_PIXEL,   13'd0,    9'd10,  9'd20,  9'd30,  1'b0, 8'd0,   8'd0,   8'd0},
    '{DO_PIXEL,   13'd0,    9'd170, 9'd85,  9'd0,   1'b0, 8'd0,   8'd0,   8'd0},
    '{DO_PIXEL,   13'd0,    9'd85,  9'd170, 9'd256, 1'b0, 8'd0,   8'd0,   8'd0},
    '{SET_WIDTH,  13'd2,    9'd0,   9'd0,   9'd0,   1'b0, 8'd0,   8'd0,   8'd0},
    '{SET_HEIGHT, 13'd1,    9'd0,   9'd0,   9'd0,   1'b0, 8'd0,   8'd0,   8'd0},
    '{DO_PIXEL,   13'd0,    9'd200, 9'd100, 9'd50,  1'b0, 8'd0,   8'd0,   8'd0},
    '{SET_WIDTH,  13'd4,    9'd0,   9'd0,   9'd0,   1'b0, 8'd0,   8'd0,   8'd0},
    '{SET_HEIGHT, 13'd1,    9'd0,   9'd0,   9'd0,   1'b0, 8'd0,   8'd0,   8'd0},
    '{DO_PIXEL,   13'd0,    9'd1,   9'd2,   9'd3,   1'b0, 8'd0,   8'd0,   8'd0},
    '{DO_PIXEL,   13'd0,    9'd64,  9'd128, 9'd192, 1'b0, 8'd0,   8'd0,   8'd0},
    '{DO_PIXEL,   13'd0,    9'd255, 9'd254, 9'd253, 1'b0, 8'd0,   8'd0,   8'd0},
    '{DO_PIXEL,   13'd0,    9'd256, 9'd0,   9'd511, 1'b0, 8'd0,   8'd0,   8'd0},
    '{SET_WIDTH,  13'd4096, 9'd0,   9'd0,   9'd0,   1'b0, 8'd0,   8'd0,   8'd0},
    '{SET_HEIGHT, 13'd8191, 9'd0,   9'd0,   9'd0,   1'b0, 8'd0,   8'd0,   8'd0},
    '{DO_PIXEL,   13'd0,    9'd99,  9'd33,  9'd77,  1'b0, 8'd0,   8'd0,   8'd0},
    '{SET_WIDTH,  13'd1,    9'd0,   9'd0,   9'd0,   1'b0, 8'd0,   8'd0,   8'd0},
    '{SET_HEIGHT, 13'd1,    9'd0,   9'd0,   9'd0,   1'b0, 8'd0,   8'd0,   8'd0},
    '{DO_PIXEL,   13'd0,    9'd300, 9'd5,   9'd256, 1'b0, 8'd0,   8'd0,   8'd0}
  };

  // Clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic int unsigned clamp_dim(dim_t v);
    if (v == '0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return v;
  endfunction

  // level * 255 / 256, truncated, saturating at 255
  function automatic logic [7:0] level_byte(level_t lvl);
    logic [17:0] prod;
    prod = (18'(lvl) * 18'd255) >> 8;
    return (prod > 18'd255) ? 8'hFF : prod[7:0];
  endfunction

  function automatic void push_le32(logic [31:0] v);
    for (int k = 0; k < 4; k++) run_bytes.push_back(v[8*k +: 8]);
  endfunction

  // Bytes one pixel brings: optional header, blue/green/red, row padding
  function automatic void encode_pixel(level_t r, level_t g, level_t b, logic fx,
                                       logic [7:0] fb, logic [7:0] fg, logic [7:0] fr);
    int unsigned w;
    int unsigned h;
    int unsigned pad;
    bit          img_done;
    file_byte_t  fb_item;
    w = clamp_dim(enc_width);
    h = clamp_dim(enc_height);
    pad = w % 4;
    img_done = 1'b0;
    run_bytes.delete();
    if (!enc_hdr_sent) begin
      run_bytes.push_back(CHAR_B);
      run_bytes.push_back(CHAR_M);
      push_le32(32'(HDR_BYTES + h * (w * 3 + pad)));
      push_le32(32'd0);
      push_le32(32'(HDR_BYTES));
      push_le32(32'(INFO_HDR_BYTES));
      push_le32(32'(w));
      push_le32(32'(h));
      run_bytes.push_back(8'd1);
      run_bytes.push_back(8'd0);
      run_bytes.push_back(8'(BITS_PER_PIXEL));
      run_bytes.push_back(8'd0);
      while (run_bytes.size() < HDR_BYTES) run_bytes.push_back(8'h00);
      enc_hdr_sent = 1'b1;
    end
    run_bytes.push_back(fx ? fb : level_byte(b));
    run_bytes.push_back(fx ? fg : level_byte(g));
    run_bytes.push_back(fx ? fr : level_byte(r));
    if (enc_col + 1 >= w) begin
      repeat (pad) run_bytes.push_back(8'h00);
      enc_col = 0;
      if (enc_row + 1 >= h) begin
        img_done = 1'b1;
        enc_row = 0;
        enc_hdr_sent = 1'b0;
      end else begin
        enc_row++;
      end
    end else begin
      enc_col++;
    end
    foreach (run_bytes[i]) begin
      fb_item.data     = run_bytes[i];
      fb_item.run_end  = (i == run_bytes.size() - 1);
      fb_item.file_end = fb_item.run_end && img_done;
      file_bytes.push_back(fb_item);
    end
  endfunction

  // Mostly short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 75) return $urandom_range(1, 3);
    if (p < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic level_t rand_level();
    case ($urandom_range(0, 9))
      0: return ($urandom_range(0, 1) != 0) ? level_t'(0) : level_t'(256);
      1: return level_t'($urandom_range(257, 511));
      default: return level_t'($urandom_range(0, 256));
    endcase
  endfunction

  // Mostly small sizes; now and then zero or at or past the maximum
  function automatic dim_t pick_dim(int unsigned top);
    case ($urandom_range(0, 19))
      0: return '0;
      1: return dim_t'($urandom_range(MAX_DIM, 8191));
      default: return dim_t'($urandom_range(1, top));
    endcase
  endfunction

  // Wait until every file byte is out, then let the block settle
  task automatic wait_drained();
    do @(posedge clk); while (file_bytes.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Register write over APB, only with nothing in flight
  task automatic write_reg(logic idx, dim_t value);
    pixel.valid <= 1'b0;
    wait_drained();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {19'($urandom), value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_WIDTH) enc_width = value;
    else enc_height = value;
  endtask

  // One pixel beat, with an optional gap in front
  task automatic send_pixel(level_t r, level_t g, level_t b, logic fx,
                            logic [7:0] fb, logic [7:0] fg, logic [7:0] fr);
    if (!quiet && $urandom_range(0, 99) < 30) begin
      pixel.valid <= 1'b0;
      repeat (pick_gap()) @(posedge clk);
    end
    pixel.valid       <= 1'b1;
    pixel.red_level   <= r;
    pixel.green_level <= g;
    pixel.blue_level  <= b;
    fixed_exp         <= fx;
    fixed_blue        <= fb;
    fixed_green       <= fg;
    fixed_red         <= fr;
    @(posedge clk);
    while (!pixel.ready) @(posedge clk);
  endtask

  // Receiver back-pressure
  always @(posedge clk) begin
    if (sink_hold != 0) begin
      sink_hold    <= sink_hold - 1;
      stream.ready <= 1'b0;
    end else begin
      stream.ready <= 1'b1;
      if (!quiet && $urandom_range(0, 99) < 25) sink_hold <= pick_gap();
    end
  end

  // Check output beats, predict on pixel beats, watch for a hang
  always @(posedge clk) begin
    file_byte_t want;
    bit         moved;
    moved = 1'b0;
    if (!rst) begin
      if (stream.valid && stream.ready) begin
        moved = 1'b1;
        if (file_bytes.size() == 0) begin
          $display("%0t: byte %02h arrived with nothing expected", $time, stream.out_byte);
          fail_count++;
        end else begin
          want = file_bytes.pop_front();
          if (stream.out_byte !== want.data) begin
            $display("%0t: out_byte expected %02h, got %02h",
                     $time, want.data, stream.out_byte);
            fail_count++;
          end
          if (stream.last_of_run !== want.run_end) begin
            $display("%0t: last_of_run expected %0b, got %0b",
                     $time, want.run_end, stream.last_of_run);
            fail_count++;
          end
          if (stream.end_of_image !== want.file_end) begin
            $display("%0t: end_of_image expected %0b, got %0b",
                     $time, want.file_end, stream.end_of_image);
            fail_count++;
          end
        end
      end
      if (pixel.valid && pixel.ready) begin
        moved = 1'b1;
        encode_pixel(pixel.red_level, pixel.green_level, pixel.blue_level,
                     fixed_exp, fixed_blue, fixed_green, fixed_red);
      end
    end
    stall_cycles = moved ? 0 : stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no beat for %0d cycles", $time, stall_cycles);
      $display("** bmp24_stream_encoder: FAILED **");
      $finish;
    end
  end

  // Stimulus
  initial begin
    int unsigned sent;
    int unsigned area;
    int unsigned n_pix;
    dim_t        w_val;
    dim_t        h_val;
    rst                = 1'b1;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    pixel.valid        = 1'b0;
    pixel.red_level    = '0;
    pixel.green_level  = '0;
    pixel.blue_level   = '0;
    fixed_exp          = 1'b0;
    fixed_blue         = '0;
    fixed_green        = '0;
    fixed_red          = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed table
    foreach (directed_rows[i]) begin
      case (directed_rows[i].kind)
        SET_WIDTH:  write_reg(REG_WIDTH, directed_rows[i].value);
        SET_HEIGHT: write_reg(REG_HEIGHT, directed_rows[i].value);
        default: begin
          send_pixel(directed_rows[i].red, directed_rows[i].green, directed_rows[i].blue,
                     directed_rows[i].fixed, directed_rows[i].exp_blue,
                     directed_rows[i].exp_green, directed_rows[i].exp_red);
        end
      endcase
    end

    // Random phases: new sizes, then mostly whole images, sometimes cut short
    sent = 0;
    while (sent < RANDOM_PIXELS) begin
      w_val = pick_dim(13);
      h_val = pick_dim(4);
      write_reg(REG_WIDTH, w_val);
      write_reg(REG_HEIGHT, h_val);
      quiet = ($urandom_range(0, 5) == 0);
      area = clamp_dim(w_val) * clamp_dim(h_val);
      if (area > 64) n_pix = $urandom_range(1, 6);
      else if ($urandom_range(0, 4) == 0) n_pix = $urandom_range(1, area);
      else n_pix = area * $urandom_range(1, 3);
      if (n_pix > RANDOM_PIXELS - sent) n_pix = RANDOM_PIXELS - sent;
      repeat (n_pix) begin
        send_pixel(rand_level(), rand_level(), rand_level(), 1'b0, 8'h00, 8'h00, 8'h00);
        sent++;
      end
    end

    pixel.valid <= 1'b0;
    wait_drained();
    if (fail_count == 0) begin
      $display("** bmp24_stream_encoder: PASSED **");
    end else begin
      $display("** bmp24_stream_encoder: FAILED **");
    end
    $finish;
  end

endmodule
